>>> src/walr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walr_pkg
// Shared types and constants of the weekday wake-up light ramp controller.
// ----------------------------------------------------------------------------
package walr_pkg;

    localparam int DAY_COUNT        = 7;
    localparam int MAX_RAMP_MINUTES = 60;

    localparam int WORD_W    = 25;
    localparam int HOLD_CFG_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int DAY_W     = 3;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int MAXP_W    = 7;
    localparam int DUTY_W    = 23;
    localparam int RAMP_W    = 12;
    localparam int HOLD_W    = 14;
    localparam int STAMP_W   = 15;

    // restoring divider: one quotient bit per cycle
    localparam int DIV_BITS  = DUTY_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [DUTY_W-1:0]  FULL_DUTY   = 23'd6553600;
    localparam logic [DUTY_W-1:0]  START_DUTY  = 23'd65536;
    localparam logic [STAMP_W-1:0] NO_STAMP    = 15'h7FFF;
    localparam logic [DAY_W-1:0]   NO_DAY      = 3'd7;
    localparam logic [MIN_W-1:0]   SEC_PER_MIN = 6'd60;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_SUNDAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MINUTES = 3'd7;

    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_CLICK = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        PH_IDLE = 2'd0,
        PH_RAMP = 2'd1,
        PH_HOLD = 2'd2
    } phase_t;

    typedef enum logic [1:0]
    {
        CS_READY = 2'd0,
        CS_DIV   = 2'd1,
        CS_EMIT  = 2'd2
    } ctrl_state_t;

    typedef struct packed
    {
        logic accept;
        logic div_step;
        logic emit;
    } walr_cmd_t;

    typedef struct packed
    {
        logic need_div;
        logic div_last;
    } walr_stat_t;

endpackage
`default_nettype wire

>>> src/walr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walr_in_if
// Input channel: one-second ticks and button clicks.
// ----------------------------------------------------------------------------
interface walr_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [walr_pkg::DAY_W-1:0]       weekday_now;
    logic [walr_pkg::HOUR_W-1:0]      hour_now;
    logic [walr_pkg::MIN_W-1:0]       minute_now;
    logic                             alarms_enabled;

    modport source
    (
        output valid, operation, weekday_now, hour_now, minute_now, alarms_enabled,
        input  ready
    );

    modport sink
    (
        input  valid, operation, weekday_now, hour_now, minute_now, alarms_enabled,
        output ready
    );
endinterface
`default_nettype wire

>>> src/walr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walr_out_if
// Output channel: one result item per input item.
// ----------------------------------------------------------------------------
interface walr_out_if;
    logic                             valid;
    logic                             ready;
    logic [walr_pkg::DUTY_W-1:0]      duty_percent;
    logic [1:0]                       phase;
    logic                             alarm_started;
    logic [walr_pkg::DAY_W-1:0]       fired_day;
    logic                             aborted;

    modport source
    (
        output valid, duty_percent, phase, alarm_started, fired_day, aborted,
        input  ready
    );

    modport sink
    (
        input  valid, duty_percent, phase, alarm_started, fired_day, aborted,
        output ready
    );
endinterface
`default_nettype wire

>>> src/walr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walr_ctrl
// Sequencer: accept, run the step divider when needed, hand off the result.
// ----------------------------------------------------------------------------
module walr_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire walr_pkg::walr_stat_t  stat,
    output      walr_pkg::walr_cmd_t   cmd
);

    walr_pkg::ctrl_state_t state_reg;
    walr_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= walr_pkg::CS_READY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            walr_pkg::CS_READY:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = stat.need_div ? walr_pkg::CS_DIV : walr_pkg::CS_EMIT;
                end
            end
            walr_pkg::CS_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = walr_pkg::CS_EMIT;
                end
            end
            walr_pkg::CS_EMIT:
            begin
                // output slot free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = walr_pkg::CS_READY;
                end
            end
            default:
            begin
                state_next = walr_pkg::CS_READY;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> src/walr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walr_datapath
// Alarm words, ramp/hold state, step divider and output register.
// ----------------------------------------------------------------------------
module walr_datapath
#(
    parameter int MAX_RAMP_MINUTES = walr_pkg::MAX_RAMP_MINUTES
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [walr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [walr_pkg::WORD_W-1:0]       cfg_wdata,
    input  wire logic                              operation,
    input  wire logic [walr_pkg::DAY_W-1:0]        weekday_now,
    input  wire logic [walr_pkg::HOUR_W-1:0]       hour_now,
    input  wire logic [walr_pkg::MIN_W-1:0]        minute_now,
    input  wire logic                              alarms_enabled,
    input  wire walr_pkg::walr_cmd_t               cmd,
    output      walr_pkg::walr_stat_t              stat,
    output      logic [walr_pkg::DUTY_W-1:0]       duty_percent,
    output      logic [1:0]                        phase,
    output      logic                              alarm_started,
    output      logic [walr_pkg::DAY_W-1:0]        fired_day,
    output      logic                              aborted
);

    // configuration
    logic [walr_pkg::WORD_W-1:0]      alarm_reg [walr_pkg::DAY_COUNT];
    logic [walr_pkg::HOLD_CFG_W-1:0]  hold_min_reg;

    // run state
    walr_pkg::phase_t                 phase_reg;
    logic [walr_pkg::DUTY_W-1:0]      duty_reg;
    logic [walr_pkg::DUTY_W-1:0]      step_reg;
    logic [walr_pkg::RAMP_W-1:0]      ramp_reg;
    logic [walr_pkg::HOLD_W-1:0]      hold_reg;
    logic [walr_pkg::STAMP_W-1:0]     stamp_reg;

    walr_pkg::phase_t                 phase_next;
    logic [walr_pkg::DUTY_W-1:0]      duty_next;
    logic [walr_pkg::DUTY_W-1:0]      step_next;
    logic [walr_pkg::RAMP_W-1:0]      ramp_next;
    logic [walr_pkg::HOLD_W-1:0]      hold_next;
    logic                             started_next;
    logic                             aborted_next;

    // staged result, then output register
    logic [walr_pkg::DUTY_W-1:0]      res_duty_reg;
    walr_pkg::phase_t                 res_phase_reg;
    logic                             res_started_reg;
    logic [walr_pkg::DAY_W-1:0]       res_day_reg;
    logic                             res_aborted_reg;

    logic [walr_pkg::DUTY_W-1:0]      out_duty_reg;
    walr_pkg::phase_t                 out_phase_reg;
    logic                             out_started_reg;
    logic [walr_pkg::DAY_W-1:0]       out_day_reg;
    logic                             out_aborted_reg;

    // divider
    logic [walr_pkg::RAMP_W-1:0]      div_rem_reg;
    logic [walr_pkg::DIV_BITS-1:0]    div_quo_reg;
    logic [walr_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [walr_pkg::RAMP_W:0]        div_shift;
    logic                             div_ge;
    logic [walr_pkg::RAMP_W-1:0]      div_rem_next;
    logic [walr_pkg::DIV_BITS-1:0]    div_quo_next;

    // item decode
    logic                             is_tick;
    logic                             wd_ok;
    logic [walr_pkg::WORD_W-1:0]      word;
    logic                             match;
    logic [walr_pkg::STAMP_W-1:0]     stamp;
    logic                             new_minute;
    logic                             start;
    logic [walr_pkg::MIN_W-1:0]       run_minutes;
    logic [walr_pkg::RAMP_W-1:0]      run_secs;
    logic [walr_pkg::HOLD_W-1:0]      hold_load;
    logic [walr_pkg::DUTY_W:0]        duty_sum;
    logic [walr_pkg::DUTY_W-1:0]      duty_sat;

    assign is_tick    = (operation == walr_pkg::OP_TICK);
    assign wd_ok      = (weekday_now < walr_pkg::DAY_W'(walr_pkg::DAY_COUNT));
    assign word       = wd_ok ? alarm_reg[weekday_now] : '0;
    assign match      = alarms_enabled && wd_ok && word[0]
                        && (word[5:1] == hour_now) && (word[11:6] == minute_now);
    assign stamp      = {1'b0, weekday_now, hour_now, minute_now};
    assign new_minute = is_tick && match && (stamp != stamp_reg);
    assign start      = new_minute && (phase_reg == walr_pkg::PH_IDLE);

    assign run_minutes = (word[17:12] > walr_pkg::MIN_W'(MAX_RAMP_MINUTES))
                         ? walr_pkg::MIN_W'(MAX_RAMP_MINUTES) : word[17:12];
    assign run_secs    = walr_pkg::RAMP_W'(run_minutes)
                         * walr_pkg::RAMP_W'(walr_pkg::SEC_PER_MIN);
    assign hold_load   = walr_pkg::HOLD_W'(hold_min_reg)
                         * walr_pkg::HOLD_W'(walr_pkg::SEC_PER_MIN);

    assign duty_sum = {1'b0, duty_reg} + {1'b0, step_reg};
    assign duty_sat = (duty_sum > {1'b0, walr_pkg::FULL_DUTY})
                      ? walr_pkg::FULL_DUTY : duty_sum[walr_pkg::DUTY_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        duty_next    = duty_reg;
        step_next    = step_reg;
        ramp_next    = ramp_reg;
        hold_next    = hold_reg;
        started_next = 1'b0;
        aborted_next = 1'b0;

        if (!is_tick)
        begin
            if (phase_reg != walr_pkg::PH_IDLE)
            begin
                phase_next   = walr_pkg::PH_IDLE;
                duty_next    = '0;
                step_next    = '0;
                ramp_next    = '0;
                hold_next    = '0;
                aborted_next = 1'b1;
            end
        end
        else if (start)
        begin
            phase_next   = walr_pkg::PH_RAMP;
            hold_next    = '0;
            step_next    = '0;   // filled in by the divider
            started_next = 1'b1;
            if (run_minutes == '0)
            begin
                duty_next = walr_pkg::FULL_DUTY;
                ramp_next = '0;
            end
            else
            begin
                duty_next = walr_pkg::START_DUTY;
                ramp_next = run_secs;
            end
        end
        else
        begin
            case (phase_reg)
                walr_pkg::PH_RAMP:
                begin
                    if (ramp_reg != '0)
                    begin
                        duty_next = duty_sat;
                        ramp_next = ramp_reg - 1'b1;
                    end
                    else if (hold_load == '0)
                    begin
                        // zero hold: ramp end drops straight to idle
                        phase_next = walr_pkg::PH_IDLE;
                        duty_next  = '0;
                        step_next  = '0;
                        ramp_next  = '0;
                        hold_next  = '0;
                    end
                    else
                    begin
                        phase_next = walr_pkg::PH_HOLD;
                        hold_next  = hold_load - 1'b1;
                    end
                end
                walr_pkg::PH_HOLD:
                begin
                    if (hold_reg == '0)
                    begin
                        phase_next = walr_pkg::PH_IDLE;
                        duty_next  = '0;
                        step_next  = '0;
                        ramp_next  = '0;
                        hold_next  = '0;
                    end
                    else
                    begin
                        hold_next = hold_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // restoring division step; divisor is the ramp length loaded at start
    assign div_shift    = {div_rem_reg, div_quo_reg[walr_pkg::DIV_BITS-1]};
    assign div_ge       = (div_shift >= {1'b0, ramp_reg});
    assign div_rem_next = div_ge ? walr_pkg::RAMP_W'(div_shift - {1'b0, ramp_reg})
                                 : div_shift[walr_pkg::RAMP_W-1:0];
    assign div_quo_next = {div_quo_reg[walr_pkg::DIV_BITS-2:0], div_ge};

    assign stat.need_div = start && (run_minutes != '0);
    assign stat.div_last = (div_cnt_reg == walr_pkg::DIV_CNT_W'(walr_pkg::DIV_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < walr_pkg::DAY_COUNT; i++)
            begin
                alarm_reg[i] <= '0;
            end
            hold_min_reg <= walr_pkg::HOLD_CFG_W'(15);
            phase_reg    <= walr_pkg::PH_IDLE;
            duty_reg     <= '0;
            step_reg     <= '0;
            ramp_reg     <= '0;
            hold_reg     <= '0;
            stamp_reg    <= walr_pkg::NO_STAMP;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == walr_pkg::REG_HOLD_MINUTES)
                begin
                    hold_min_reg <= cfg_wdata[walr_pkg::HOLD_CFG_W-1:0];
                end
                else if (cfg_index >= walr_pkg::REG_ALARM_SUNDAY
                         && cfg_index < walr_pkg::CFG_IDX_W'(walr_pkg::DAY_COUNT))
                begin
                    alarm_reg[cfg_index] <= cfg_wdata;
                end
            end

            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                duty_reg  <= duty_next;
                step_reg  <= step_next;
                ramp_reg  <= ramp_next;
                hold_reg  <= hold_next;
                if (new_minute)
                begin
                    stamp_reg <= stamp;
                end
            end
            else if (cmd.div_step && stat.div_last)
            begin
                step_reg <= div_quo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_duty_reg    <= (phase_next == walr_pkg::PH_IDLE) ? '0 : duty_next;
            res_phase_reg   <= phase_next;
            res_started_reg <= started_next;
            res_day_reg     <= started_next ? weekday_now : walr_pkg::NO_DAY;
            res_aborted_reg <= aborted_next;
            div_rem_reg     <= '0;
            div_quo_reg     <= {word[24:18], 16'd0};
            div_cnt_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end

        if (cmd.emit)
        begin
            out_duty_reg    <= res_duty_reg;
            out_phase_reg   <= res_phase_reg;
            out_started_reg <= res_started_reg;
            out_day_reg     <= res_day_reg;
            out_aborted_reg <= res_aborted_reg;
        end
    end

    assign duty_percent  = out_duty_reg;
    assign phase         = out_phase_reg;
    assign alarm_started = out_started_reg;
    assign fired_day     = out_day_reg;
    assign aborted       = out_aborted_reg;

endmodule
`default_nettype wire

>>> src/weekday_alarm_light_ramp_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted item is written to the staging register, then to the output register once
//   the output slot is free; a tick that starts a ramp of nonzero length first runs the step divider.
// Items: a new item is taken only after the last one has left the staging register; a ramp start
//   also waits for the one-bit-per-cycle restoring divider that computes the ramp step.
// Reset: rst_n (async, active low) clears alarm words to 0, hold_minutes to 15,
//   goes idle with zero duty and forgets the last fired minute. No clearing pass.
// ----------------------------------------------------------------------------
// weekday_alarm_light_ramp_top
// Wake-up light alarm: per-weekday alarm words start a duty ramp that rises
// each one-second tick, holds (unless hold time is 0), then turns off; a button click aborts it.
// ----------------------------------------------------------------------------
module weekday_alarm_light_ramp_top
#(
    parameter int MAX_RAMP_MINUTES = walr_pkg::MAX_RAMP_MINUTES
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port, no read-back
    input  wire logic                            cfg_wr_en,
    input  wire logic [walr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [walr_pkg::WORD_W-1:0]     cfg_wdata,
    // item channels
    walr_in_if.sink                              in_ch,
    walr_out_if.source                           out_ch
);

    walr_pkg::walr_cmd_t  cmd;
    walr_pkg::walr_stat_t stat;

    // The controller owns the handshakes. It takes an item whenever it is
    // back in its ready state, even if the previous result still sits in the
    // output register: results wait in a staging register until the slot frees.
    walr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath evaluates the whole item in its accept cycle (match,
    // once-per-minute check, ramp/hold advance or abort). Only the ramp step,
    // max*65536 / (minutes*60), is left to the iterative divider.
    walr_datapath
    #(
        .MAX_RAMP_MINUTES (MAX_RAMP_MINUTES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .operation      (in_ch.operation),
        .weekday_now    (in_ch.weekday_now),
        .hour_now       (in_ch.hour_now),
        .minute_now     (in_ch.minute_now),
        .alarms_enabled (in_ch.alarms_enabled),
        .cmd            (cmd),
        .stat           (stat),
        .duty_percent   (out_ch.duty_percent),
        .phase          (out_ch.phase),
        .alarm_started  (out_ch.alarm_started),
        .fired_day      (out_ch.fired_day),
        .aborted        (out_ch.aborted)
    );

endmodule
`default_nettype wire
